/* hdl/ohlcv_candle_aggregator_assert.svh */
// Assertion macros for the candle aggregator; only ohca_ctrl uses them.
// Each use expects signals clk and rst_n in the enclosing module.
`ifndef OHLCV_CANDLE_AGGREGATOR_ASSERT_SVH
`define OHLCV_CANDLE_AGGREGATOR_ASSERT_SVH

// Same-cycle implication
`define OHCA_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("candle aggregator check failed");

// Next-cycle implication
`define OHCA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("candle aggregator check failed");

`endif

/* hdl/ohca_pkg.sv */
// Shared constants, divider operation codes and control structs of the
// candle aggregator. No dependencies.
package ohca_pkg;

    localparam int TIME_BITS_DEF  = 48;
    localparam int PRICE_BITS_DEF = 32;
    localparam int VOL_BITS       = 48;
    localparam int CNT_BITS       = 32;
    localparam int SUM_BITS       = 64;
    localparam int DIV_BITS       = 64;
    localparam logic [CNT_BITS-1:0] WIDTH_RESET = 32'd60;

    // Divider operations
    typedef enum logic [1:0] {
        DOP_ALIGN,
        DOP_GAP,
        DOP_AVG,
        DOP_WAVG
    } div_op_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    capture;
        logic    div_start;
        div_op_t div_op;
        logic    latch;
        logic    emit;
        logic    open;
        logic    acc;
        logic    clear;
    } ohca_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic started;
        logic flush;
        logic close_needed;
        logic div_done;
        logic out_free;
    } ohca_sts_t;

endpackage

/* hdl/ohca_divider.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Uses ohca_pkg for the default width.
module ohca_divider #(
    parameter int WIDTH = ohca_pkg::DIV_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);
    localparam int CW = $clog2(WIDTH);

    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] dvs_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;

    // One restoring step
    always_comb
    begin
        trial = {rem_reg, quo_reg[WIDTH-1]};
        diff  = trial - {1'b0, dvs_reg};
        if (!diff[WIDTH])
        begin
            rem_next = diff[WIDTH-1:0];
            quo_next = {quo_reg[WIDTH-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[WIDTH-1:0];
            quo_next = {quo_reg[WIDTH-2:0], 1'b0};
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(WIDTH - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operands and partial results
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

/* hdl/ohca_datapath.sv */
// Candle state, accumulators, operand capture and result register.
// Uses ohca_pkg and instantiates ohca_divider.
module ohca_datapath #(
    parameter int TIME_BITS  = ohca_pkg::TIME_BITS_DEF,
    parameter int PRICE_BITS = ohca_pkg::PRICE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ohca_pkg::ohca_cmd_t               cmd,
    output ohca_pkg::ohca_sts_t               sts,
    input  logic                              cfg_wr_en,
    input  logic [ohca_pkg::CNT_BITS-1:0]     cfg_wr_data,
    input  logic                              mode,
    input  logic [TIME_BITS-1:0]              timestamp,
    input  logic [PRICE_BITS-1:0]             price,
    input  logic [ohca_pkg::CNT_BITS-1:0]     volume,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [TIME_BITS-1:0]              start_time,
    output logic [PRICE_BITS-1:0]             open_price,
    output logic [PRICE_BITS-1:0]             high_price,
    output logic [PRICE_BITS-1:0]             low_price,
    output logic [PRICE_BITS-1:0]             close_price,
    output logic [ohca_pkg::VOL_BITS-1:0]     volume_up,
    output logic [ohca_pkg::VOL_BITS-1:0]     volume_down,
    output logic [ohca_pkg::VOL_BITS-1:0]     volume_flat,
    output logic [ohca_pkg::CNT_BITS-1:0]     trade_count,
    output logic [PRICE_BITS-1:0]             avg_price,
    output logic [PRICE_BITS-1:0]             avg_weighted_price,
    output logic [ohca_pkg::CNT_BITS-1:0]     empty_before
);
    localparam int VB = ohca_pkg::VOL_BITS;
    localparam int CB = ohca_pkg::CNT_BITS;
    localparam int SB = ohca_pkg::SUM_BITS;
    localparam int DB = ohca_pkg::DIV_BITS;
    localparam int PB = PRICE_BITS + CB;

    // Captured request and config
    logic                  cap_mode_reg;
    logic [TIME_BITS-1:0]  cap_ts_reg;
    logic [PRICE_BITS-1:0] cap_price_reg;
    logic [CB-1:0]         cap_vol_reg;
    logic [PB-1:0]         prod_reg;
    logic [CB-1:0]         width_reg;

    // Candle state
    logic                  started_reg;
    logic [TIME_BITS-1:0]  ws_reg;
    logic [PRICE_BITS-1:0] open_reg, high_reg, low_reg, close_reg, prev_reg;
    logic [VB-1:0]         up_reg, down_reg, flat_reg;
    logic [CB-1:0]         trades_reg, gap_reg;
    logic [SB-1:0]         psum_reg, wsum_reg;

    // Division results
    logic [PRICE_BITS-1:0] avg_reg, wavg_reg;
    logic [TIME_BITS-1:0]  ns_reg;
    logic [CB-1:0]         gaps_reg;

    // Result register
    logic                  out_valid_reg;
    logic [TIME_BITS-1:0]  o_start_reg;
    logic [PRICE_BITS-1:0] o_open_reg, o_high_reg, o_low_reg, o_close_reg;
    logic [VB-1:0]         o_up_reg, o_down_reg, o_flat_reg;
    logic [CB-1:0]         o_trades_reg, o_avg_pad, o_gap_reg;
    logic [PRICE_BITS-1:0] o_avg_reg, o_wavg_reg;

    logic [CB-1:0]         w_eff;
    logic [TIME_BITS-1:0]  ts_diff;
    logic [VB+1:0]         vol_total;
    logic [DB-1:0]         div_a, div_b, quot, rem;
    logic                  div_done;
    logic [DB-1:0]         q_less;
    logic [PRICE_BITS-1:0] q_price;
    logic                  div_by_zero;

    logic [VB:0]           up_sum, down_sum, flat_sum;
    logic [CB:0]           trades_sum;
    logic [SB:0]           psum_sum, wsum_sum;

    assign w_eff     = (width_reg == '0) ? CB'(1) : width_reg;
    assign ts_diff   = cap_ts_reg - ws_reg;
    assign vol_total = (VB+2)'(up_reg) + (VB+2)'(down_reg) + (VB+2)'(flat_reg);
    assign o_avg_pad = '0;

    // Select divider operands
    always_comb
    begin
        unique case (cmd.div_op)
            ohca_pkg::DOP_ALIGN:
            begin
                div_a = DB'(cap_ts_reg);
                div_b = DB'(w_eff);
            end
            ohca_pkg::DOP_GAP:
            begin
                div_a = DB'(ts_diff);
                div_b = DB'(w_eff);
            end
            ohca_pkg::DOP_AVG:
            begin
                div_a = psum_reg;
                div_b = DB'(trades_reg);
            end
            default:
            begin
                div_a = wsum_reg;
                div_b = DB'(vol_total);
            end
        endcase
    end

    ohca_divider #(.WIDTH(DB)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (quot),
        .remainder (rem)
    );

    // Saturate quotient to a price, and form k minus one
    assign div_by_zero = (div_b == '0);
    assign q_price = (|quot[DB-1:PRICE_BITS]) ? {PRICE_BITS{1'b1}} : quot[PRICE_BITS-1:0];
    assign q_less  = quot - DB'(1);

    // Saturating sums for accumulation
    assign up_sum     = {1'b0, up_reg} + (VB+1)'(cap_vol_reg);
    assign down_sum   = {1'b0, down_reg} + (VB+1)'(cap_vol_reg);
    assign flat_sum   = {1'b0, flat_reg} + (VB+1)'(cap_vol_reg);
    assign trades_sum = {1'b0, trades_reg} + (CB+1)'(1);
    assign psum_sum   = {1'b0, psum_reg} + (SB+1)'(cap_price_reg);
    assign wsum_sum   = {1'b0, wsum_reg} + (SB+1)'(prod_reg);

    // Capture request, config, product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            width_reg <= ohca_pkg::WIDTH_RESET;
        else if (cfg_wr_en)
            width_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cap_mode_reg  <= mode;
            cap_ts_reg    <= timestamp;
            cap_price_reg <= price;
            cap_vol_reg   <= volume;
        end
        prod_reg <= PB'(cap_price_reg) * PB'(cap_vol_reg);
    end

    // Latch division results
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            unique case (cmd.div_op)
                ohca_pkg::DOP_ALIGN:
                begin
                    ns_reg   <= cap_ts_reg - rem[TIME_BITS-1:0];
                    gaps_reg <= '0;
                end
                ohca_pkg::DOP_GAP:
                begin
                    ns_reg   <= cap_ts_reg - rem[TIME_BITS-1:0];
                    gaps_reg <= (|q_less[DB-1:CB]) ? {CB{1'b1}} : q_less[CB-1:0];
                end
                ohca_pkg::DOP_AVG:
                    avg_reg <= div_by_zero ? close_reg : q_price;
                default:
                    wavg_reg <= div_by_zero ? close_reg : q_price;
            endcase
        end
    end

    // Candle state: clear, open, accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            ws_reg      <= '0;
            open_reg    <= '0;
            high_reg    <= '0;
            low_reg     <= '0;
            close_reg   <= '0;
            prev_reg    <= '0;
            up_reg      <= '0;
            down_reg    <= '0;
            flat_reg    <= '0;
            trades_reg  <= '0;
            gap_reg     <= '0;
            psum_reg    <= '0;
            wsum_reg    <= '0;
        end
        else if (cmd.clear)
        begin
            started_reg <= 1'b0;
            ws_reg      <= '0;
            open_reg    <= '0;
            high_reg    <= '0;
            low_reg     <= '0;
            close_reg   <= '0;
            prev_reg    <= '0;
            up_reg      <= '0;
            down_reg    <= '0;
            flat_reg    <= '0;
            trades_reg  <= '0;
            gap_reg     <= '0;
            psum_reg    <= '0;
            wsum_reg    <= '0;
        end
        else if (cmd.open)
        begin
            started_reg <= 1'b1;
            ws_reg      <= ns_reg;
            open_reg    <= cap_price_reg;
            high_reg    <= cap_price_reg;
            low_reg     <= cap_price_reg;
            close_reg   <= cap_price_reg;
            up_reg      <= '0;
            down_reg    <= '0;
            flat_reg    <= '0;
            trades_reg  <= '0;
            gap_reg     <= gaps_reg;
            psum_reg    <= '0;
            wsum_reg    <= '0;
        end
        else if (cmd.acc)
        begin
            if (cap_price_reg > high_reg)
                high_reg <= cap_price_reg;
            if (cap_price_reg < low_reg)
                low_reg <= cap_price_reg;
            close_reg <= cap_price_reg;
            if (cap_price_reg > prev_reg)
                up_reg <= up_sum[VB] ? {VB{1'b1}} : up_sum[VB-1:0];
            else if (cap_price_reg < prev_reg)
                down_reg <= down_sum[VB] ? {VB{1'b1}} : down_sum[VB-1:0];
            else
                flat_reg <= flat_sum[VB] ? {VB{1'b1}} : flat_sum[VB-1:0];
            prev_reg   <= cap_price_reg;
            trades_reg <= trades_sum[CB] ? {CB{1'b1}} : trades_sum[CB-1:0];
            psum_reg   <= psum_sum[SB] ? {SB{1'b1}} : psum_sum[SB-1:0];
            wsum_reg   <= wsum_sum[SB] ? {SB{1'b1}} : wsum_sum[SB-1:0];
        end
    end

    // Result valid: set on emit, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            o_start_reg  <= ws_reg;
            o_open_reg   <= open_reg;
            o_high_reg   <= high_reg;
            o_low_reg    <= low_reg;
            o_close_reg  <= close_reg;
            o_up_reg     <= up_reg;
            o_down_reg   <= down_reg;
            o_flat_reg   <= flat_reg;
            o_trades_reg <= trades_reg | o_avg_pad;
            o_avg_reg    <= avg_reg;
            o_wavg_reg   <= wavg_reg;
            o_gap_reg    <= gap_reg;
        end
    end

    // Status
    always_comb
    begin
        sts.started      = started_reg;
        sts.flush        = cap_mode_reg;
        sts.close_needed = (cap_ts_reg >= ws_reg) && (ts_diff >= TIME_BITS'(w_eff));
        sts.div_done     = div_done;
        sts.out_free     = !out_valid_reg || !out_stall;
    end

    assign out_valid          = out_valid_reg;
    assign start_time         = o_start_reg;
    assign open_price         = o_open_reg;
    assign high_price         = o_high_reg;
    assign low_price          = o_low_reg;
    assign close_price        = o_close_reg;
    assign volume_up          = o_up_reg;
    assign volume_down        = o_down_reg;
    assign volume_flat        = o_flat_reg;
    assign trade_count        = o_trades_reg;
    assign avg_price          = o_avg_reg;
    assign avg_weighted_price = o_wavg_reg;
    assign empty_before       = o_gap_reg;
endmodule

/* hdl/ohca_ctrl.sv */
// Sequencing state machine of the candle aggregator.
// Uses ohca_pkg and the assertion macros header.
`include "ohlcv_candle_aggregator_assert.svh"

module ohca_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ohca_pkg::ohca_sts_t sts,
    output ohca_pkg::ohca_cmd_t cmd
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DSTART,
        S_DWAIT,
        S_EMIT,
        S_OPEN,
        S_ACC
    } state_t;

    state_t            state_reg, state_next;
    ohca_pkg::div_op_t op_reg, op_next;
    logic              accepting;

    assign accepting = (state_reg == S_IDLE) || (state_reg == S_ACC);
    assign in_stall  = !accepting;

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        cmd           = '0;
        cmd.div_op    = op_reg;
        cmd.capture   = accepting && in_valid;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                if (sts.flush)
                begin
                    if (sts.started)
                    begin
                        op_next    = ohca_pkg::DOP_AVG;
                        state_next = S_DSTART;
                    end
                    else
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (!sts.started)
                begin
                    op_next    = ohca_pkg::DOP_ALIGN;
                    state_next = S_DSTART;
                end
                else if (sts.close_needed)
                begin
                    op_next    = ohca_pkg::DOP_AVG;
                    state_next = S_DSTART;
                end
                else
                    state_next = S_ACC;
            end
            S_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.latch = 1'b1;
                    unique case (op_reg)
                        ohca_pkg::DOP_AVG:
                        begin
                            op_next    = ohca_pkg::DOP_WAVG;
                            state_next = S_DSTART;
                        end
                        ohca_pkg::DOP_WAVG:
                            state_next = S_EMIT;
                        default:
                            state_next = S_OPEN;
                    endcase
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.flush)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        op_next    = ohca_pkg::DOP_GAP;
                        state_next = S_DSTART;
                    end
                end
            end
            S_OPEN:
            begin
                cmd.open   = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = in_valid ? S_MUL : S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Hold state and operation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= ohca_pkg::DOP_ALIGN;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    `OHCA_ASSERT_NEXT(a_accept_to_mul, cmd.capture, state_reg == S_MUL)
    `OHCA_ASSERT_NOW(a_emit_when_free, cmd.emit, sts.out_free)
    `OHCA_ASSERT_NEXT(a_div_runs, cmd.div_start, state_reg == S_DWAIT && !sts.div_done)
endmodule

/* hdl/ohlcv_candle_aggregator.sv */
// OHLCV candle aggregator: a tick inside the open window goes through S_MUL and then
// S_ACC, which already takes the next tick. A first tick runs one divide to align the window.
// A tick that closes a candle runs three divides (the two averages and the gap count,
// and the emit before the gap count waits for a free output); a flush with an open candle runs two.
// The result appears in the output register when the candle closes.
// Reset (rst_n, asynchronous) clears all candle state and sets the width to 60.
module ohlcv_candle_aggregator #(
    parameter int TIME_BITS  = ohca_pkg::TIME_BITS_DEF,
    parameter int PRICE_BITS = ohca_pkg::PRICE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [ohca_pkg::CNT_BITS-1:0] cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          mode,
    input  logic [TIME_BITS-1:0]          timestamp,
    input  logic [PRICE_BITS-1:0]         price,
    input  logic [ohca_pkg::CNT_BITS-1:0] volume,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [TIME_BITS-1:0]          start_time,
    output logic [PRICE_BITS-1:0]         open_price,
    output logic [PRICE_BITS-1:0]         high_price,
    output logic [PRICE_BITS-1:0]         low_price,
    output logic [PRICE_BITS-1:0]         close_price,
    output logic [ohca_pkg::VOL_BITS-1:0] volume_up,
    output logic [ohca_pkg::VOL_BITS-1:0] volume_down,
    output logic [ohca_pkg::VOL_BITS-1:0] volume_flat,
    output logic [ohca_pkg::CNT_BITS-1:0] trade_count,
    output logic [PRICE_BITS-1:0]         avg_price,
    output logic [PRICE_BITS-1:0]         avg_weighted_price,
    output logic [ohca_pkg::CNT_BITS-1:0] empty_before
);
    ohca_pkg::ohca_cmd_t cmd;
    ohca_pkg::ohca_sts_t sts;

    ohca_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    ohca_datapath #(
        .TIME_BITS  (TIME_BITS),
        .PRICE_BITS (PRICE_BITS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .mode               (mode),
        .timestamp          (timestamp),
        .price              (price),
        .volume             (volume),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .start_time         (start_time),
        .open_price         (open_price),
        .high_price         (high_price),
        .low_price          (low_price),
        .close_price        (close_price),
        .volume_up          (volume_up),
        .volume_down        (volume_down),
        .volume_flat        (volume_flat),
        .trade_count        (trade_count),
        .avg_price          (avg_price),
        .avg_weighted_price (avg_weighted_price),
        .empty_before       (empty_before)
    );
endmodule
